@@ src/light_level_hysteresis_detector_unit_assert.svh @@
// Assertion macros shared by the light level detector modules
`ifndef LIGHT_LEVEL_HYSTERESIS_DETECTOR_UNIT_ASSERT_SVH
`define LIGHT_LEVEL_HYSTERESIS_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication under synchronous reset
`define LLHD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// next-cycle implication under synchronous reset
`define LLHD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

@@ src/llhd_pkg.sv @@
// Shared types and constants of the light level hysteresis detector
package llhd_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int WINDOW_MAX_DEF  = 255;
   localparam int THR_W           = 12;
   localparam int WIN_W           = 8;
   localparam int CSR_DATA_W      = 12;
   localparam int CSR_IDX_W       = 2;

   localparam logic [THR_W-1:0] OPEN_RESET   = 12'd3000;
   localparam logic [THR_W-1:0] CLOSE_RESET  = 12'd1000;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 2'd0,
      CSR_OPEN   = 2'd1,
      CSR_CLOSE  = 2'd2,
      CSR_WINDOW = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_DARK   = 2'd1,
      EV_BRIGHT = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      ZONE_MID   = 2'd0,
      ZONE_UPPER = 2'd1,
      ZONE_LOWER = 2'd2
   } zone_type;

   typedef enum logic [1:0] {
      PH_BRIGHT  = 2'd0,
      PH_FALLING = 2'd1,
      PH_DARK    = 2'd2,
      PH_RISING  = 2'd3
   } phase_type;

   typedef struct packed {
      logic              enable;
      logic [THR_W-1:0]  open_thr;
      logic [THR_W-1:0]  close_thr;
      logic [WIN_W-1:0]  window_len;
   } cfg_type;

endpackage

@@ src/llhd_csr.sv @@
// Configuration register bank of the light level detector
module llhd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [llhd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [llhd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output llhd_pkg::cfg_type                 cfg
);
   import llhd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ENABLE: cfg_in.enable     = csr_wdata[0];
            CSR_OPEN:   cfg_in.open_thr   = csr_wdata[THR_W-1:0];
            CSR_CLOSE:  cfg_in.close_thr  = csr_wdata[THR_W-1:0];
            CSR_WINDOW: cfg_in.window_len = csr_wdata[WIN_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable     <= 1'b1;
         cfg_ff.open_thr   <= OPEN_RESET;
         cfg_ff.close_thr  <= CLOSE_RESET;
         cfg_ff.window_len <= WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/llhd_div.sv @@
// Bit-serial restoring divider for the window average
`include "light_level_hysteresis_detector_unit_assert.svh"

module llhd_div #(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic                  qbit;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      qbit   = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], qbit};
         cnt_in = CNT_W'(cnt_ff - CNT_W'(1));
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   `LLHD_ASSERT_IMP(a_div_done_idle, clock, reset, done_ff, !busy_ff)
   `LLHD_ASSERT_IMP(a_div_busy_cnt, clock, reset, busy_ff, cnt_ff != '0)
   `LLHD_ASSERT_IMP(a_div_start_free, clock, reset, start, !busy_ff)

endmodule

@@ src/light_level_hysteresis_detector_unit.sv @@
// Top level of the light level hysteresis detector
//
//   port group | direction | handshake          | payload
//   req_       | in        | req_valid/req_ready | req_sample
//   rsp_       | out       | rsp_valid/rsp_ready | rsp_event_code, rsp_zone, rsp_phase
//   csr_       | in        | csr_we              | csr_index, csr_wdata
//
// A request passes through accept, evaluate and hand to output register, and
// when it closes a window it also waits in ST_DIV for the bit-serial divider
// that forms the window average one quotient bit a cycle.
// One request is in work at a time; the next is accepted while a result waits.
// A stalled result holds the block before the output register is reloaded.
// Reset is synchronous; the block accepts a request in the cycle after reset.
`include "light_level_hysteresis_detector_unit_assert.svh"

module light_level_hysteresis_detector_unit #(
   parameter int SAMPLE_BITS = llhd_pkg::SAMPLE_BITS_DEF,
   parameter int WINDOW_MAX  = llhd_pkg::WINDOW_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [SAMPLE_BITS-1:0]          req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_event_code,
   output logic [1:0]                      rsp_zone,
   output logic [1:0]                      rsp_phase,
   input  logic                            csr_we,
   input  logic [llhd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [llhd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import llhd_pkg::*;

   localparam int SUM_BITS = SAMPLE_BITS + WIN_W;
   localparam logic [WIN_W-1:0] WIN_MAX_V = WIN_W'(WINDOW_MAX);

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EVAL = 2'd1,
      ST_DIV  = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   cfg_type cfg;

   state_type              state_ff, state_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   zone_type               zone_ff, zone_in;
   event_type              event_ff, event_in;
   phase_type              phase_ff, phase_in;
   logic [WIN_W-1:0]       count_ff, count_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   event_type              rsp_event_ff, rsp_event_in;
   zone_type               rsp_zone_ff, rsp_zone_in;
   phase_type              rsp_phase_ff, rsp_phase_in;

   logic [WIN_W-1:0]    eff_win;
   logic [SUM_BITS-1:0] sample_ext;
   logic [SUM_BITS-1:0] open_ext;
   logic [SUM_BITS-1:0] close_ext;
   zone_type            zone_calc;
   logic                div_start;
   logic                div_busy;
   logic                div_done;
   logic [SUM_BITS-1:0] div_quo;

   llhd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   llhd_div #(
      .DIVIDEND_W (SUM_BITS),
      .DIVISOR_W  (WIN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (eff_win),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      if (cfg.window_len == '0) begin
         eff_win = WIN_W'(1);
      end else if (cfg.window_len > WIN_MAX_V) begin
         eff_win = WIN_MAX_V;
      end else begin
         eff_win = cfg.window_len;
      end
      sample_ext = SUM_BITS'(sample_ff);
      open_ext   = SUM_BITS'(cfg.open_thr);
      close_ext  = SUM_BITS'(cfg.close_thr);
      if (sample_ext > open_ext) begin
         zone_calc = ZONE_UPPER;
      end else if (sample_ext < close_ext) begin
         zone_calc = ZONE_LOWER;
      end else begin
         zone_calc = ZONE_MID;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      zone_in      = zone_ff;
      event_in     = event_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_event_in = rsp_event_ff;
      rsp_zone_in  = rsp_zone_ff;
      rsp_phase_in = rsp_phase_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            event_in = EV_NONE;
            zone_in  = ZONE_MID;
            state_in = ST_DONE;
            if (cfg.enable) begin
               zone_in = zone_calc;
               unique case (phase_ff)
                  PH_BRIGHT: begin
                     if (zone_calc == ZONE_LOWER) begin
                        count_in = eff_win;
                        phase_in = PH_FALLING;
                     end
                  end
                  PH_DARK: begin
                     if (zone_calc == ZONE_UPPER) begin
                        count_in = eff_win;
                        phase_in = PH_RISING;
                     end
                  end
                  PH_FALLING, PH_RISING: begin
                     count_in = WIN_W'(count_ff - WIN_W'(1));
                     sum_in   = SUM_BITS'(sum_ff + sample_ext);
                     if (count_ff == WIN_W'(1)) begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               sum_in   = '0;
               state_in = ST_DONE;
               if (phase_ff == PH_FALLING) begin
                  if (zone_ff == ZONE_LOWER && div_quo <= close_ext) begin
                     event_in = EV_DARK;
                     phase_in = PH_DARK;
                  end else begin
                     phase_in = PH_RISING;
                     count_in = eff_win;
                  end
               end else begin
                  if (zone_ff == ZONE_UPPER && div_quo >= open_ext) begin
                     event_in = EV_BRIGHT;
                     phase_in = PH_BRIGHT;
                  end else begin
                     phase_in = PH_FALLING;
                  end
                  count_in = eff_win;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = event_ff;
               rsp_zone_in  = zone_ff;
               rsp_phase_in = phase_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_RISING;
         count_ff     <= WINDOW_RESET;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      zone_ff      <= zone_in;
      event_ff     <= event_in;
      rsp_event_ff <= rsp_event_in;
      rsp_zone_ff  <= rsp_zone_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_event_ff;
   assign rsp_zone       = rsp_zone_ff;
   assign rsp_phase      = rsp_phase_ff;

   `LLHD_ASSERT_IMP(a_div_in_div_state, clock, reset, div_done, state_ff == ST_DIV)
   `LLHD_ASSERT_IMP(a_div_state_live, clock, reset, state_ff == ST_DIV, div_busy || div_done)
   `LLHD_ASSERT_IMP(a_count_live, clock, reset,
      state_ff == ST_IDLE && (phase_ff == PH_FALLING || phase_ff == PH_RISING),
      count_ff != '0)
   `LLHD_ASSERT_IMP(a_event_phase, clock, reset,
      rsp_valid_ff && rsp_event_ff != EV_NONE,
      (rsp_event_ff == EV_DARK && rsp_phase_ff == PH_DARK) ||
      (rsp_event_ff == EV_BRIGHT && rsp_phase_ff == PH_BRIGHT))

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the light level hysteresis detector unit
`timescale 1ns / 1ps

module tb;
   import llhd_pkg::*;

   typedef struct packed {
      event_type ev;
      zone_type  zn;
      phase_type ph;
   } light_result_type;

   typedef enum int {
      RUN_BRIGHT,
      RUN_DARK,
      RUN_MID,
      RUN_NOISE
   } run_kind_type;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 30;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [11:0]           req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_event_code;
   logic [1:0]            rsp_zone;
   logic [1:0]            rsp_phase;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of configuration and state
   logic         cfg_enable = 1'b1;
   logic [11:0]  cfg_open   = OPEN_RESET;
   logic [11:0]  cfg_close  = CLOSE_RESET;
   logic [7:0]   cfg_window = WINDOW_RESET;
   phase_type    lvl_phase  = PH_RISING;
   logic [7:0]   lvl_count  = WINDOW_RESET;
   logic [19:0]  lvl_sum    = '0;

   logic [11:0]      pending_samples [$];
   light_result_type expected_results [$];

   int  gap_cnt = 0;
   int  stall_cnt = 0;
   int  hold_req = 0;
   int  hold_seen = 0;
   int  err_cnt = 0;
   int  idle_cycles = 0;
   int  queued = 0;
   logic burst_mode = 1'b0;

   light_level_hysteresis_detector_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_code (rsp_event_code),
      .rsp_zone       (rsp_zone),
      .rsp_phase      (rsp_phase),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic light_result_type classify_light(logic [11:0] s);
      light_result_type r;
      int               w;
      zone_type         z;
      r.ev = EV_NONE;
      z = ZONE_MID;
      if (cfg_enable) begin
         w = (cfg_window == 8'd0) ? 1 : int'(cfg_window);
         if (s > cfg_open) z = ZONE_UPPER;
         else if (s < cfg_close) z = ZONE_LOWER;
         case (lvl_phase)
            PH_BRIGHT: begin
               if (z == ZONE_LOWER) begin
                  lvl_count = 8'(w);
                  lvl_phase = PH_FALLING;
               end
            end
            PH_FALLING: begin
               lvl_count = lvl_count - 8'd1;
               lvl_sum = lvl_sum + 20'(s);
               if (lvl_count == 8'd0) begin
                  if (z == ZONE_LOWER && int'(lvl_sum) / w <= int'(cfg_close)) begin
                     r.ev = EV_DARK;
                     lvl_phase = PH_DARK;
                  end else begin
                     lvl_phase = PH_RISING;
                     lvl_count = 8'(w);
                  end
                  lvl_sum = '0;
               end
            end
            PH_DARK: begin
               if (z == ZONE_UPPER) begin
                  lvl_count = 8'(w);
                  lvl_phase = PH_RISING;
               end
            end
            default: begin
               lvl_count = lvl_count - 8'd1;
               lvl_sum = lvl_sum + 20'(s);
               if (lvl_count == 8'd0) begin
                  if (z == ZONE_UPPER && int'(lvl_sum) / w >= int'(cfg_open)) begin
                     r.ev = EV_BRIGHT;
                     lvl_phase = PH_BRIGHT;
                  end else begin
                     lvl_phase = PH_FALLING;
                  end
                  lvl_count = 8'(w);
                  lvl_sum = '0;
               end
            end
         endcase
      end
      r.zn = z;
      r.ph = lvl_phase;
      return r;
   endfunction

   task automatic log_error(string msg);
      if (err_cnt < 10) $display("ERROR @%0t: %s", $realtime, msg);
      err_cnt++;
   endtask

   // request driver
   always @(posedge clock) begin : drive
      light_result_type r;
      if (reset) begin
         req_valid <= 1'b0;
         gap_cnt <= 0;
      end else begin
         if (req_valid && req_ready) begin
            r = classify_light(req_sample);
            expected_results.push_back(r);
         end
         if (!req_valid || req_ready) begin
            if (gap_cnt > 0) begin
               gap_cnt <= gap_cnt - 1;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_valid <= 1'b1;
               req_sample <= pending_samples.pop_front();
               gap_cnt <= burst_mode ? 0 : $urandom_range(0, 13);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : monitor
      light_result_type r;
      int               nstall;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_cnt <= 0;
      end else begin
         nstall = stall_cnt;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               log_error($sformatf("result without request: ev=%0d zone=%0d phase=%0d",
                                   rsp_event_code, rsp_zone, rsp_phase));
            end else begin
               r = expected_results.pop_front();
               if (rsp_event_code !== r.ev || rsp_zone !== r.zn || rsp_phase !== r.ph)
                  log_error($sformatf({"mismatch: expected ev=%0d zone=%0d phase=%0d,",
                                       " got ev=%0d zone=%0d phase=%0d"},
                                      r.ev, r.zn, r.ph,
                                      rsp_event_code, rsp_zone, rsp_phase));
            end
            nstall = burst_mode ? 0 : $urandom_range(0, 13);
         end
         if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            nstall = LONG_HOLD;
         end
         if (nstall > 0) begin
            rsp_ready <= 1'b0;
            stall_cnt <= nstall - 1;
         end else begin
            rsp_ready <= 1'b1;
            stall_cnt <= 0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic apply_config(logic en, logic [11:0] op, logic [11:0] cl, logic [7:0] win);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_ENABLE;
      csr_wdata <= CSR_DATA_W'(en);
      cfg_enable = en;
      @(posedge clock);
      csr_index <= CSR_OPEN;
      csr_wdata <= op;
      cfg_open = op;
      @(posedge clock);
      csr_index <= CSR_CLOSE;
      csr_wdata <= cl;
      cfg_close = cl;
      @(posedge clock);
      csr_index <= CSR_WINDOW;
      csr_wdata <= CSR_DATA_W'(win);
      cfg_window = win;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_run(run_kind_type kind, int len);
      logic [11:0] s;
      for (int i = 0; i < len; i++) begin
         case (kind)
            RUN_BRIGHT: s = (cfg_open == 12'hfff) ? 12'hfff :
                            12'($urandom_range(int'(cfg_open) + 1, 4095));
            RUN_DARK:   s = (cfg_close == 12'd0) ? 12'd0 :
                            12'($urandom_range(0, int'(cfg_close) - 1));
            RUN_MID:    s = (cfg_close <= cfg_open) ?
                            12'($urandom_range(int'(cfg_close), int'(cfg_open))) :
                            12'($urandom);
            default:    s = 12'($urandom);
         endcase
         pending_samples.push_back(s);
         queued++;
      end
   endtask

   function automatic logic [11:0] pick_level(int lo, int hi);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 12'd0;
      if (sel == 1) return 12'hfff;
      if (sel == 2) return 12'($urandom);
      return 12'($urandom_range(lo, hi));
   endfunction

   initial begin : stimulus
      logic [11:0] directed_list [25] = '{
         12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
         12'd3000, 12'd1000, 12'd999,
         12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
         12'd3001,
         12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd2000,
         12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd3000
      };
      logic [11:0]  op;
      logic [11:0]  cl;
      logic [7:0]   win;
      logic         en;
      int           ph;
      int           weff;
      int           phase_items;
      int           sel;
      run_kind_type kind;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_list[i]) pending_samples.push_back(directed_list[i]);
      wait_idle();

      apply_config(1'b0, 12'd3000, 12'd1000, 8'd5);
      pending_samples.push_back(12'd4095);
      pending_samples.push_back(12'd0);
      pending_samples.push_back(12'd2048);
      wait_idle();

      apply_config(1'b1, 12'd0, 12'd4095, 8'd0);
      pending_samples.push_back(12'd0);
      pending_samples.push_back(12'd4095);
      pending_samples.push_back(12'd1);
      pending_samples.push_back(12'd0);
      pending_samples.push_back(12'd4095);
      wait_idle();

      queued = 0;
      ph = 0;
      while (queued < 500) begin
         if (ph == 2) begin
            apply_config(1'b1, 12'd3000, 12'd1000, 8'd255);
            burst_mode = 1'b1;
            queue_run(RUN_BRIGHT, 257);
         end else begin
            en = ($urandom_range(0, 7) != 0);
            op = pick_level(2048, 4000);
            cl = pick_level(50, 2000);
            sel = $urandom_range(0, 9);
            if (sel == 0) win = 8'd0;
            else if (sel == 1) win = 8'($urandom_range(9, 40));
            else win = 8'($urandom_range(1, 8));
            apply_config(en, op, cl, win);
            burst_mode = (ph == 1) || ($urandom_range(0, 3) == 0);
            weff = (win == 8'd0) ? 1 : int'(win);
            phase_items = 0;
            while (phase_items < 30) begin
               sel = $urandom_range(0, 19);
               if (sel < 7) kind = RUN_BRIGHT;
               else if (sel < 14) kind = RUN_DARK;
               else if (sel < 16) kind = RUN_MID;
               else kind = RUN_NOISE;
               queue_run(kind, (kind == RUN_NOISE) ? $urandom_range(1, 4) :
                                weff + $urandom_range(0, 3));
               phase_items += weff + 1;
            end
            if (ph == 1) hold_req++;
         end
         wait_idle();
         ph++;
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_results.size() != 0)
         log_error($sformatf("%0d results never arrived", expected_results.size()));
      if (err_cnt == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
